/* design/mcr_pkg.sv */
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; imported by every module of the block.
package mcr_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int POINTS_PER_STEP = 8;
  localparam int PT_IDX_BITS     = $clog2(POINTS_PER_STEP);
  localparam int DEC_ADD_EAST    = 3;
  localparam int DEC_ADD_SOUTH   = 5;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

/* design/midpoint_circle_rasterizer.sv */
// Top level of the midpoint circle rasterizer: front end, job queue, back end.
// Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back.
//
//   channel   handshake            payload
//   input     push / full          op, center_x, center_y, radius
//   result    empty / pop          pixel_x, pixel_y, last_of_step, circle_done
//
// A start or step item is taken while full is low; the front end updates x, y and the decision
// value in that cycle and queues one job. The back end sends one point per cycle while pop keeps
// up, so each productive item yields eight points; sustained throughput is set by the single
// result port. Steps while idle are taken but change no state and queue no job.
// Synchronous reset clears the circle state, the queue and the output valid flag and point index.
// full rises when the job queue is full; a stalled pop holds the current point.
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         op,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [COORD_BITS-1:0]        radius,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last_of_step,
  output logic                         circle_done
);
  import mcr_pkg::*;

  localparam int JW = 4 * COORD_BITS + 1;

  q_stat_t         q_stat;
  logic            q_push;
  logic            q_pop;
  logic [JW-1:0]   q_wdata;
  logic [JW-1:0]   q_rdata;

  mcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .op       (op),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  mcr_queue #(
    .WIDTH (JW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  mcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

/* design/mcr_front.sv */
// Front end: takes start/step items, runs the decision update, pushes point jobs.
// Depends on mcr_pkg.
module mcr_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      op,
  input  logic [COORD_BITS-1:0]     center_x,
  input  logic [COORD_BITS-1:0]     center_y,
  input  logic [COORD_BITS-1:0]     radius,
  input  mcr_pkg::q_stat_t          q_stat,
  output logic                      q_push,
  output logic [4*COORD_BITS:0]     q_data
);
  import mcr_pkg::*;

  localparam int DB = COORD_BITS + 3;

  logic [COORD_BITS-1:0] cur_x, cur_x_next;
  logic [COORD_BITS-1:0] cur_y, cur_y_next;
  logic [DB-1:0]         decision_var, decision_var_next;
  logic [COORD_BITS-1:0] held_center_x, held_center_x_next;
  logic [COORD_BITS-1:0] held_center_y, held_center_y_next;
  logic                  active, active_next;
  logic                  accept;
  logic                  done;
  logic [DB-1:0]         x_ext, y_ext, r_ext;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;
  assign x_ext  = DB'(cur_x);
  assign y_ext  = DB'(cur_y);
  assign r_ext  = DB'(radius);

  always_comb begin
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    decision_var_next  = decision_var;
    held_center_x_next = held_center_x;
    held_center_y_next = held_center_y;
    if (op_t'(op) == OP_START) begin
      cur_x_next         = '0;
      cur_y_next         = radius;
      decision_var_next  = DB'(1) - r_ext;
      held_center_x_next = center_x;
      held_center_y_next = center_y;
    end else begin
      if (decision_var[DB-1]) begin
        decision_var_next = decision_var + (x_ext << 1) + DB'(DEC_ADD_EAST);
      end else begin
        decision_var_next = decision_var + ((x_ext - y_ext) << 1) + DB'(DEC_ADD_SOUTH);
        cur_y_next        = cur_y - COORD_BITS'(1);
      end
      cur_x_next = cur_x + COORD_BITS'(1);
    end
    done        = !(cur_y_next > cur_x_next);
    active_next = !done;
    q_push      = accept && (op_t'(op) == OP_START || active);
    q_data      = {done, held_center_x_next, held_center_y_next, cur_x_next, cur_y_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      cur_x         <= '0;
      cur_y         <= '0;
      decision_var  <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
    end else if (q_push) begin
      active        <= active_next;
      cur_x         <= cur_x_next;
      cur_y         <= cur_y_next;
      decision_var  <= decision_var_next;
      held_center_x <= held_center_x_next;
      held_center_y <= held_center_y_next;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_idle_step_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && op_t'(op) == OP_STEP && !active) |=> $stable(cur_x) && $stable(cur_y)
      && $stable(decision_var))
    else $error("step while idle changed state");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_data[4*COORD_BITS]) |=> !active)
    else $error("finished circle left active");

endmodule

/* design/mcr_queue.sv */
// Job queue between the front and back ends.
// Depends on mcr_pkg.
module mcr_queue #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  output logic [WIDTH-1:0]  rd_data,
  output mcr_pkg::q_stat_t  stat
);
  import mcr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign stat.not_empty = (count != '0);
  assign stat.full      = (count == CW'(DEPTH));
  assign rd_data        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> stat.not_empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* design/mcr_back.sv */
// Back end: expands one job into eight symmetric points, one a cycle unless pop stalls, into an output register.
// Depends on mcr_pkg.
module mcr_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mcr_pkg::q_stat_t             q_stat,
  input  logic [4*COORD_BITS:0]        q_data,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last_of_step,
  output logic                         circle_done
);
  import mcr_pkg::*;

  localparam int PB = COORD_BITS + 2;

  logic [PT_IDX_BITS-1:0] pt_idx;
  logic                   out_valid;
  logic                   load;
  logic                   pt_last;
  logic                   job_done;
  logic [COORD_BITS-1:0]  job_cx, job_cy, job_x, job_y;
  logic [COORD_BITS-1:0]  ex, ey;
  logic                   neg_x, neg_y;
  logic signed [PB-1:0]   dx, dy, px, py;

  assign {job_done, job_cx, job_cy, job_x, job_y} = q_data;

  always_comb begin
    ex      = pt_idx[2] ? job_y : job_x;
    ey      = pt_idx[2] ? job_x : job_y;
    neg_x   = pt_idx[2] ? pt_idx[0] : pt_idx[1];
    neg_y   = pt_idx[2] ? pt_idx[1] : pt_idx[0];
    dx      = neg_x ? -$signed({2'b00, ex}) : $signed({2'b00, ex});
    dy      = neg_y ? -$signed({2'b00, ey}) : $signed({2'b00, ey});
    px      = $signed({2'b00, job_cx}) + dx;
    py      = $signed({2'b00, job_cy}) + dy;
    pt_last = (pt_idx == PT_IDX_BITS'(POINTS_PER_STEP - 1));
    load    = q_stat.not_empty && (!out_valid || pop);
    q_pop   = load && pt_last;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pt_idx    <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pt_idx    <= pt_idx + PT_IDX_BITS'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x      <= px;
      pixel_y      <= py;
      last_of_step <= pt_last;
      circle_done  <= job_done;
    end
  end

  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    load |=> (last_of_step == $past(pt_last)) && !empty)
    else $error("output register not loaded with current point");

  a_idx_wraps: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> pt_idx == '0)
    else $error("point index not back at first point after job");

endmodule

/* test/midpoint_circle_rasterizer_tb.sv */
// Self-checking testbench for midpoint_circle_rasterizer: random and directed
// start/step commands, eight predicted points per productive command.
// Depends on mcr_pkg and the midpoint_circle_rasterizer RTL.
module midpoint_circle_rasterizer_tb;
  import mcr_pkg::*;

  localparam int CB        = COORD_BITS_DEF;
  localparam int LIMIT     = 400000;
  localparam int DRAIN     = 40;
  localparam int MAX_PRINT = 40;

  typedef struct {
    op_t           op;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [CB-1:0] rad;
  } circle_cmd_t;

  typedef struct {
    logic signed [CB+1:0] px;
    logic signed [CB+1:0] py;
    logic                 last;
    logic                 done;
  } circle_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic op = OP_START;
  logic [CB-1:0] center_x = '0;
  logic [CB-1:0] center_y = '0;
  logic [CB-1:0] radius = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [CB+1:0] pixel_x;
  logic signed [CB+1:0] pixel_y;
  logic last_of_step;
  logic circle_done;

  circle_cmd_t   cmd_queue[$];
  circle_point_t pending_points[$];

  logic [CB-1:0]        pos_x = '0;
  logic [CB-1:0]        pos_y = '0;
  logic signed [CB+2:0] dec = '0;
  logic [CB-1:0]        ctr_x = '0;
  logic [CB-1:0]        ctr_y = '0;
  logic                 busy = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int cmd_count = 0;

  midpoint_circle_rasterizer DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .op(op),
    .center_x(center_x),
    .center_y(center_y),
    .radius(radius),
    .empty(empty),
    .pop(pop),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .last_of_step(last_of_step),
    .circle_done(circle_done)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINT) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    mismatch_count++;
  endtask

  function automatic void add_point(int dx, int dy, bit last, bit fin);
    circle_point_t p;
    int ax;
    int ay;
    ax = int'(ctr_x) + dx;
    ay = int'(ctr_y) + dy;
    p.px = ax[CB+1:0];
    p.py = ay[CB+1:0];
    p.last = last;
    p.done = fin;
    pending_points.push_back(p);
  endfunction

  function automatic void advance_circle(circle_cmd_t c);
    int d;
    int x;
    int y;
    bit fin;
    if (c.op == OP_START) begin
      ctr_x = c.cx;
      ctr_y = c.cy;
      pos_x = '0;
      pos_y = c.rad;
      d = 1 - int'(c.rad);
      dec = d[CB+2:0];
    end else begin
      if (!busy) return;
      d = int'(dec);
      x = int'(pos_x);
      y = int'(pos_y);
      if (d < 0) begin
        d += 2 * x + DEC_ADD_EAST;
      end else begin
        d += 2 * (x - y) + DEC_ADD_SOUTH;
        y--;
      end
      x++;
      dec = d[CB+2:0];
      pos_x = x[CB-1:0];
      pos_y = y[CB-1:0];
    end
    fin = !(pos_y > pos_x);
    busy = !fin;
    x = int'(pos_x);
    y = int'(pos_y);
    add_point(x, y, 1'b0, fin);
    add_point(x, -y, 1'b0, fin);
    add_point(-x, y, 1'b0, fin);
    add_point(-x, -y, 1'b0, fin);
    add_point(y, x, 1'b0, fin);
    add_point(-y, x, 1'b0, fin);
    add_point(y, -x, 1'b0, fin);
    add_point(-y, -x, 1'b1, fin);
  endfunction

  task automatic add_cmd(op_t o, int cx, int cy, int rad);
    circle_cmd_t c;
    c.op = o;
    c.cx = cx[CB-1:0];
    c.cy = cy[CB-1:0];
    c.rad = rad[CB-1:0];
    cmd_queue.push_back(c);
    cmd_count++;
  endtask

  task automatic add_step();
    add_cmd(OP_STEP, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
  endtask

  // one circle: mostly small radii run to completion, some abandoned early
  task automatic add_circle();
    int rad;
    int steps;
    int sel;
    sel = $urandom_range(99);
    if (sel < 6) rad = 0;
    else if (sel < 14) rad = $urandom_range(1023);
    else rad = $urandom_range(1, 24);
    add_cmd(OP_START, $urandom_range(1023), $urandom_range(1023), rad);
    if (rad > 24) steps = $urandom_range(12);
    else if ($urandom_range(99) < 20) steps = $urandom_range(rad / 2);
    else steps = (rad * 3) / 4 + 1 + $urandom_range(2);
    repeat (steps) add_step();
  endtask

  task automatic wait_cmds_taken();
    while (cmd_queue.size() != 0) @(posedge clk);
  endtask

  // driver: present the head of the queue, hold until transfer
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        advance_circle(cmd_queue[0]);
        void'(cmd_queue.pop_front());
      end
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        op <= cmd_queue[0].op;
        center_x <= cmd_queue[0].cx;
        center_y <= cmd_queue[0].cy;
        radius <= cmd_queue[0].rad;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: check each point transfer against the oldest prediction
  always @(posedge clk) begin
    circle_point_t p;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point (%0d,%0d)", pixel_x, pixel_y));
        end else begin
          p = pending_points.pop_front();
          if (pixel_x !== p.px)
            report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, p.px));
          if (pixel_y !== p.py)
            report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, p.py));
          if (last_of_step !== p.last)
            report_mismatch($sformatf("last_of_step %b, want %b", last_of_step, p.last));
          if (circle_done !== p.done)
            report_mismatch($sformatf("circle_done %b, want %b", circle_done, p.done));
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout: %0d points outstanding", pending_points.size());
      $display("midpoint_circle_rasterizer verification failed");
      $finish;
    end
  end

  initial begin
    int target;
    int ph;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_cmd(OP_STEP, 1023, 1023, 1023);
    add_cmd(OP_START, 0, 0, 0);
    add_cmd(OP_STEP, 0, 0, 0);
    add_cmd(OP_START, 1023, 1023, 1023);
    repeat (3) add_cmd(OP_STEP, 0, 1023, 0);
    add_cmd(OP_START, 0, 0, 1023);
    repeat (2) add_cmd(OP_STEP, 1023, 0, 1023);
    add_cmd(OP_START, 512, 300, 1);
    repeat (2) add_cmd(OP_STEP, 0, 0, 0);
    add_cmd(OP_START, 5, 1020, 3);
    repeat (4) add_cmd(OP_STEP, 0, 0, 0);
    add_cmd(OP_START, 1023, 0, 2);
    repeat (2) add_cmd(OP_STEP, 0, 0, 0);
    wait_cmds_taken();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          send_idle_pct = 72;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 72;
        end
        3: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      target = cmd_count + 22;
      while (cmd_count < target) begin
        if ($urandom_range(99) < 10) add_step();
        else add_circle();
      end
      wait_cmds_taken();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("midpoint_circle_rasterizer verification clean");
    end else begin
      $display("midpoint_circle_rasterizer verification failed");
    end
    $finish;
  end

endmodule
